// ===== hw/rtl/sptm_pkg.sv =====
// sptm_pkg: constants, command codes and term type for the sparse polynomial merge adder
// no dependencies; imported by sparse_poly_term_merge_add_unit

package sptm_pkg;

   // list depth and kept exponent bits
   localparam int DEPTH    = 16;
   localparam int EXP_BITS = 8;

   // fixed field widths of the channels
   localparam int CMD_W   = 2;
   localparam int COEFF_W = 16;
   localparam int TEXP_W  = 8;
   localparam int SUM_W   = COEFF_W + 1;

   // derived widths
   localparam int STORE_EXP_W = (EXP_BITS < TEXP_W) ? EXP_BITS : TEXP_W;
   localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W       = $clog2(DEPTH + 1);

   // command codes
   localparam logic [CMD_W-1:0] CMD_LOAD_FIRST  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_SECOND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RUN         = 2'd2;

   typedef struct packed {
      logic signed [COEFF_W-1:0] coeff;
      logic [STORE_EXP_W-1:0]    exp;
   } term_type;

endpackage

// ===== hw/rtl/sparse_poly_term_merge_add_unit.sv =====
// sparse_poly_term_merge_add_unit: top level of the sparse polynomial adder (sorted merge)
// depends on sptm_pkg for widths, command codes and the stored term type
//
//   channel | dir | handshake            | payload
//   req     | in  | req_valid/req_ready  | cmd, term_coeff, term_exp
//   rsp     | out | rsp_valid/rsp_ready  | sum_coeff, sum_exp, last, empty_res
//
// a load transfer leaves the block idle, so it is ready again at once
// a run does one merge step per cycle through the single compare/add unit, unless the
//   output slot is busy, and then pushes the final term
// req_ready is low for the whole run; a stalled rsp channel holds the merge step
// synchronous active-high reset clears counts, sequencer and output valid;
//   the term stores hold no reset value

module sparse_poly_term_merge_add_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [sptm_pkg::CMD_W-1:0]          req_cmd,
   input  logic signed [sptm_pkg::COEFF_W-1:0] req_term_coeff,
   input  logic [sptm_pkg::TEXP_W-1:0]         req_term_exp,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [sptm_pkg::SUM_W-1:0]   rsp_sum_coeff,
   output logic [sptm_pkg::TEXP_W-1:0]         rsp_sum_exp,
   output logic                                rsp_last,
   output logic                                rsp_empty_res
);

   import sptm_pkg::*;

   localparam logic [0:0] ST_IDLE  = 1'b0;
   localparam logic [0:0] ST_MERGE = 1'b1;

   // term stores, one write port each, read at the walk index
   term_type first_terms_ff  [DEPTH];
   term_type second_terms_ff [DEPTH];

   logic [CNT_W-1:0] first_count_ff, first_count_in;
   logic [CNT_W-1:0] second_count_ff, second_count_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [0:0]       state_ff, state_in;

   // one held-back term so that the final one can carry last
   logic                       pend_valid_ff, pend_valid_in;
   logic signed [SUM_W-1:0]    pend_coeff_ff, pend_coeff_in;
   logic [STORE_EXP_W-1:0]     pend_exp_ff, pend_exp_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0]    rsp_coeff_ff, rsp_coeff_in;
   logic [TEXP_W-1:0]          rsp_exp_ff, rsp_exp_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       rsp_empty_ff, rsp_empty_in;

   logic     req_xfer;
   logic     load_first, load_second;
   term_type load_term;
   term_type a_term, b_term;
   logic     a_ok, b_ok;
   logic signed [SUM_W-1:0] a_ext, b_ext, ab_sum;
   logic     produce, advance, finish, slot_free, push;
   logic     step_i, step_j;
   logic signed [SUM_W-1:0] new_coeff;
   logic [STORE_EXP_W-1:0]  new_exp;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;

   assign load_term.coeff = req_term_coeff;
   assign load_term.exp   = req_term_exp[STORE_EXP_W-1:0];

   assign load_first  = req_xfer && (req_cmd == CMD_LOAD_FIRST)
                        && (first_count_ff < CNT_W'(DEPTH));
   assign load_second = req_xfer && (req_cmd == CMD_LOAD_SECOND)
                        && (second_count_ff < CNT_W'(DEPTH));

   always_ff @(posedge clock) begin
      if (load_first) begin
         first_terms_ff[first_count_ff[IDX_W-1:0]] <= load_term;
      end
      if (load_second) begin
         second_terms_ff[second_count_ff[IDX_W-1:0]] <= load_term;
      end
   end

   // shared compare/add unit: one merge step per cycle, unless the output slot is busy
   assign a_term = first_terms_ff[i_ff[IDX_W-1:0]];
   assign b_term = second_terms_ff[j_ff[IDX_W-1:0]];
   assign a_ok   = (i_ff < first_count_ff);
   assign b_ok   = (j_ff < second_count_ff);
   assign a_ext  = {a_term.coeff[COEFF_W-1], a_term.coeff};
   assign b_ext  = {b_term.coeff[COEFF_W-1], b_term.coeff};
   assign ab_sum = a_ext + b_ext;

   always_comb begin
      step_i    = 1'b0;
      step_j    = 1'b0;
      produce   = 1'b0;
      new_coeff = a_ext;
      new_exp   = a_term.exp;
      if (a_ok && b_ok) begin
         if (a_term.exp == b_term.exp) begin
            step_i    = 1'b1;
            step_j    = 1'b1;
            new_coeff = ab_sum;
            produce   = (ab_sum != '0);
         end else if (a_term.exp > b_term.exp) begin
            step_i  = 1'b1;
            produce = 1'b1;
         end else begin
            step_j    = 1'b1;
            produce   = 1'b1;
            new_coeff = b_ext;
            new_exp   = b_term.exp;
         end
      end else if (a_ok) begin
         step_i  = 1'b1;
         produce = 1'b1;
      end else if (b_ok) begin
         step_j    = 1'b1;
         produce   = 1'b1;
         new_coeff = b_ext;
         new_exp   = b_term.exp;
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign finish    = (state_ff == ST_MERGE) && !a_ok && !b_ok && slot_free;
   // a produced term displaces the held one, which needs the output slot
   assign advance   = (state_ff == ST_MERGE) && (a_ok || b_ok)
                      && (!produce || !pend_valid_ff || slot_free);
   assign push      = finish || (advance && produce && pend_valid_ff);

   // sequencer, walk indices and counts
   always_comb begin
      state_in        = state_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      pend_valid_in   = pend_valid_ff;
      pend_coeff_in   = pend_coeff_ff;
      pend_exp_in     = pend_exp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (load_first) begin
               first_count_in = first_count_ff + CNT_W'(1);
            end
            if (load_second) begin
               second_count_in = second_count_ff + CNT_W'(1);
            end
            if (req_xfer && (req_cmd == CMD_RUN)) begin
               state_in      = ST_MERGE;
               i_in          = '0;
               j_in          = '0;
               pend_valid_in = 1'b0;
            end
         end
         ST_MERGE: begin
            if (advance) begin
               if (step_i) begin
                  i_in = i_ff + CNT_W'(1);
               end
               if (step_j) begin
                  j_in = j_ff + CNT_W'(1);
               end
               if (produce) begin
                  pend_valid_in = 1'b1;
                  pend_coeff_in = new_coeff;
                  pend_exp_in   = new_exp;
               end
            end
            if (finish) begin
               state_in        = ST_IDLE;
               first_count_in  = '0;
               second_count_in = '0;
               pend_valid_in   = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register: held term, or the empty marker at the end of an empty sum
   always_comb begin
      rsp_coeff_in = rsp_coeff_ff;
      rsp_exp_in   = rsp_exp_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      if (push) begin
         rsp_coeff_in = pend_valid_ff ? pend_coeff_ff : '0;
         rsp_exp_in   = pend_valid_ff ? TEXP_W'(pend_exp_ff) : '0;
         rsp_last_in  = finish;
         rsp_empty_in = finish && !pend_valid_ff;
      end
      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         i_ff            <= '0;
         j_ff            <= '0;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         i_ff            <= i_in;
         j_ff            <= j_in;
         pend_valid_ff   <= pend_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_coeff_ff <= pend_coeff_in;
      pend_exp_ff   <= pend_exp_in;
      rsp_coeff_ff  <= rsp_coeff_in;
      rsp_exp_ff    <= rsp_exp_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sum_coeff = rsp_coeff_ff;
   assign rsp_sum_exp   = rsp_exp_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_empty_res = rsp_empty_ff;

`ifndef SYNTH
   // a run transfer starts the merge walk
   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_cmd == CMD_RUN)) |=> (state_ff == ST_MERGE))
      else $error("run transfer did not start merge");

   // walk indices never pass the list counts
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |-> ((i_ff <= first_count_ff) && (j_ff <= second_count_ff)))
      else $error("merge index beyond list count");

   // the empty marker is always a final, all-zero term
   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_res) |-> (rsp_last && (rsp_sum_coeff == '0)
                                        && (rsp_sum_exp == '0)))
      else $error("malformed empty result");

   // a finished run leaves both lists cleared
   a_lists_cleared: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_MERGE) ##1 (state_ff == ST_IDLE))
         |-> ((first_count_ff == '0) && (second_count_ff == '0)))
      else $error("lists not cleared after run");
`endif

endmodule
